[hw/rtl/fixed_point_q24_8_alu_macros.svh]
// assertion macros for the fixed-point alu, empty under synthesis
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FXALU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fxalu: check failed");
// next-cycle implication
`define FXALU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fxalu: check failed");
`else
`define FXALU_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define FXALU_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/fxalu_pkg.sv]
// command codes and constants for the fixed-point alu
package fxalu_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 8;
	localparam logic [DATA_W-1:0] ONE_LSB = 32'h0000_0001;

	localparam logic [3:0] CMD_ADD      = 4'd0;
	localparam logic [3:0] CMD_SUB      = 4'd1;
	localparam logic [3:0] CMD_MUL      = 4'd2;
	localparam logic [3:0] CMD_DIV      = 4'd3;
	localparam logic [3:0] CMD_LT       = 4'd4;
	localparam logic [3:0] CMD_GT       = 4'd5;
	localparam logic [3:0] CMD_LE       = 4'd6;
	localparam logic [3:0] CMD_GE       = 4'd7;
	localparam logic [3:0] CMD_EQ       = 4'd8;
	localparam logic [3:0] CMD_NE       = 4'd9;
	localparam logic [3:0] CMD_MIN      = 4'd10;
	localparam logic [3:0] CMD_MAX      = 4'd11;
	localparam logic [3:0] CMD_INC      = 4'd12;
	localparam logic [3:0] CMD_DEC      = 4'd13;
	localparam logic [3:0] CMD_TO_INT   = 4'd14;
	localparam logic [3:0] CMD_FROM_INT = 4'd15;

endpackage

[hw/rtl/fixed_point_q24_8_alu.sv]
// signed fixed-point alu, raw two's complement operands with FRAC_BITS fraction bits
// stages in order: s1, s2, one divider stage per quotient bit, s3, s4; default Q24.8
// throughput: one word per cycle unless m_tready stalls; the restoring divider retires
// one quotient bit per stage; each stage stalls on its own, so bubbles collapse and the
// input is ready while a stage is empty; arst_n clears all valid bits, no data registers
`include "fixed_point_q24_8_alu_macros.svh"

module fixed_point_q24_8_alu
	import fxalu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
	input  logic [3:0]  s_tuser,   // command[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // result_value[31:0], compare_true[32], overflow[33],
	                               // divide_by_zero[34], zero[39:35]
);

	// numerator / quotient width of the divider
	localparam int NW = DATA_W + FRAC_BITS;
	localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic [3:0]        cmd;
		logic [DATA_W-1:0] res;
		logic              cmp;
		logic              ovf;
		logic              dz;
		logic              neg;
		logic [63:0]       mag;
		logic [NW-1:0]     nq;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] den;
	} pipe_t;

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic              rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	pipe_t             dat_s1, dat_s2, dat_s3;
	pipe_t             nxt_s1, nxt_s2, nxt_s3;
	logic              vld_sdiv [NW];
	logic              rdy_sdiv [NW];
	pipe_t             dat_sdiv [NW];
	logic [DATA_W-1:0] res_s4, res_nx;
	logic              cmp_s4, ovf_s4, dz_s4, ovf_nx;

	logic signed [DATA_W-1:0] op_a, op_b;
	logic signed [63:0]       prod;
	logic [DATA_W:0]          sum_w;
	logic [FRAC_BITS:0]       int_top;

	assign op_a = s_tdata[DATA_W-1:0];
	assign op_b = s_tdata[63:DATA_W];

	// ready chain, each stage takes a word when empty or when it moves on
	assign rdy_s4   = !vld_s4 | m_tready;
	assign rdy_s3   = !vld_s3 | rdy_s4;
	assign rdy_s2   = !vld_s2 | rdy_sdiv[0];
	assign rdy_s1   = !vld_s1 | rdy_s2;
	assign s_tready = rdy_s1;

	// stage 1: simple ops, product, divider operands
	always_comb begin
		prod    = op_a * op_b;
		sum_w   = '0;
		int_top = op_a[DATA_W-1 -: FRAC_BITS+1];
		nxt_s1  = '0;
		nxt_s1.cmd = s_tuser;
		nxt_s1.mag = prod;
		nxt_s1.nq  = {(op_a[DATA_W-1] ? DATA_W'(0) - op_a : op_a), {FRAC_BITS{1'b0}}};
		nxt_s1.den = op_b[DATA_W-1] ? DATA_W'(0) - op_b : op_b;
		case (s_tuser)
			CMD_ADD: begin
				sum_w      = {op_a[DATA_W-1], op_a} + {op_b[DATA_W-1], op_b};
				nxt_s1.res = sum_w[DATA_W-1:0];
				nxt_s1.ovf = sum_w[DATA_W] ^ sum_w[DATA_W-1];
			end
			CMD_SUB: begin
				sum_w      = {op_a[DATA_W-1], op_a} - {op_b[DATA_W-1], op_b};
				nxt_s1.res = sum_w[DATA_W-1:0];
				nxt_s1.ovf = sum_w[DATA_W] ^ sum_w[DATA_W-1];
			end
			CMD_MUL: begin
				nxt_s1.res = '0;
			end
			CMD_DIV: begin
				nxt_s1.dz  = (op_b == '0);
				nxt_s1.neg = op_a[DATA_W-1] ^ op_b[DATA_W-1];
			end
			CMD_LT:  nxt_s1.cmp = (op_a < op_b);
			CMD_GT:  nxt_s1.cmp = (op_a > op_b);
			CMD_LE:  nxt_s1.cmp = (op_a <= op_b);
			CMD_GE:  nxt_s1.cmp = (op_a >= op_b);
			CMD_EQ:  nxt_s1.cmp = (op_a == op_b);
			CMD_NE:  nxt_s1.cmp = (op_a != op_b);
			CMD_MIN: nxt_s1.res = (op_a > op_b) ? op_b : op_a;
			CMD_MAX: nxt_s1.res = (op_a > op_b) ? op_a : op_b;
			CMD_INC: begin
				sum_w      = {op_a[DATA_W-1], op_a} + {1'b0, ONE_LSB};
				nxt_s1.res = sum_w[DATA_W-1:0];
				nxt_s1.ovf = sum_w[DATA_W] ^ sum_w[DATA_W-1];
			end
			CMD_DEC: begin
				sum_w      = {op_a[DATA_W-1], op_a} - {1'b0, ONE_LSB};
				nxt_s1.res = sum_w[DATA_W-1:0];
				nxt_s1.ovf = sum_w[DATA_W] ^ sum_w[DATA_W-1];
			end
			CMD_TO_INT: nxt_s1.res = op_a >>> FRAC_BITS;
			CMD_FROM_INT: begin
				nxt_s1.res = op_a << FRAC_BITS;
				nxt_s1.ovf = !((&int_top) || !(|int_top));
			end
			default: nxt_s1.res = '0;
		endcase
	end

	// stage 2: product magnitude and sign
	always_comb begin
		nxt_s2 = dat_s1;
		if (dat_s1.cmd == CMD_MUL) begin
			nxt_s2.neg = dat_s1.mag[63];
			nxt_s2.mag = dat_s1.mag[63] ? 64'(0) - dat_s1.mag : dat_s1.mag;
		end
	end

	// divider stages, one quotient bit each
	for (genvar i = 0; i < NW; i++) begin : g_div
		pipe_t         din, dnx;
		logic          vin;
		logic          rnext;
		logic [DATA_W:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign din = dat_s2;
			assign vin = vld_s2;
		end else begin : g_mid
			assign din = dat_sdiv[i-1];
			assign vin = vld_sdiv[i-1];
		end

		if (i == NW - 1) begin : g_last
			assign rnext = rdy_s3;
		end else begin : g_inner
			assign rnext = rdy_sdiv[i+1];
		end

		assign rdy_sdiv[i] = !vld_sdiv[i] | rnext;

		// restoring step on the running remainder
		always_comb begin
			trial   = {din.rem, din.nq[NW-1]};
			ge      = (trial >= {1'b0, din.den});
			dnx     = din;
			dnx.rem = ge ? DATA_W'(trial - {1'b0, din.den}) : trial[DATA_W-1:0];
			dnx.nq  = {din.nq[NW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sdiv[i] <= 1'b0;
			end else if (rdy_sdiv[i]) begin
				vld_sdiv[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_sdiv[i]) begin
				dat_sdiv[i] <= dnx;
			end
		end
	end

	// stage 3: round half away from zero on the magnitude
	always_comb begin
		nxt_s3 = dat_sdiv[NW-1];
		if (dat_sdiv[NW-1].cmd == CMD_MUL) begin
			nxt_s3.mag = (dat_sdiv[NW-1].mag + HALF) >> FRAC_BITS;
		end else if (dat_sdiv[NW-1].cmd == CMD_DIV) begin
			nxt_s3.mag = {{(64-NW){1'b0}}, dat_sdiv[NW-1].nq}
				+ 64'({dat_sdiv[NW-1].rem, 1'b0} >= {1'b0, dat_sdiv[NW-1].den});
		end
	end

	// stage 4: restore sign, wrap and range check
	always_comb begin
		res_nx = dat_s3.res;
		ovf_nx = dat_s3.ovf;
		if (dat_s3.cmd == CMD_MUL || (dat_s3.cmd == CMD_DIV && !dat_s3.dz)) begin
			if (dat_s3.neg) begin
				res_nx = DATA_W'(0) - dat_s3.mag[DATA_W-1:0];
				ovf_nx = (|dat_s3.mag[63:DATA_W])
					|| (dat_s3.mag[DATA_W-1] && (|dat_s3.mag[DATA_W-2:0]));
			end else begin
				res_nx = dat_s3.mag[DATA_W-1:0];
				ovf_nx = |dat_s3.mag[63:DATA_W-1];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_sdiv[NW-1];
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (rdy_s1) dat_s1 <= nxt_s1;
		if (rdy_s2) dat_s2 <= nxt_s2;
		if (rdy_s3) dat_s3 <= nxt_s3;
		if (rdy_s4) begin
			res_s4 <= res_nx;
			cmp_s4 <= dat_s3.cmp;
			ovf_s4 <= ovf_nx;
			dz_s4  <= dat_s3.dz;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {5'b0, dz_s4, ovf_s4, cmp_s4, res_s4};

	// checks
	`FXALU_ASSERT_IMP(a_dz_clean, clk, arst_n, m_tvalid && dz_s4,
		res_s4 == '0 && !ovf_s4 && !cmp_s4)
	`FXALU_ASSERT_IMP(a_cmp_clean, clk, arst_n, m_tvalid && cmp_s4,
		res_s4 == '0 && !ovf_s4 && !dz_s4)
	`FXALU_ASSERT_IMP(a_rem_bound, clk, arst_n,
		vld_s3 && dat_s3.cmd == CMD_DIV && !dat_s3.dz, dat_s3.rem < dat_s3.den)
	`FXALU_ASSERT_NXT(a_dz_entry, clk, arst_n,
		s_tvalid && s_tready && s_tuser == CMD_DIV && s_tdata[63:DATA_W] == '0,
		vld_s1 && dat_s1.dz)

endmodule

[tb/tb.sv]
// testbench for the q24.8 fixed-point alu: directed corners, random words, scoreboard check
`timescale 1ns / 1ps

module tb;
	import fxalu_pkg::*;

	localparam int      FB            = FRAC_BITS_DEF;
	localparam int      RANDOM_WORDS  = 1625;
	localparam int      CALM_FIRST    = 600;
	localparam int      CALM_LAST     = 900;
	localparam int      IDLE_PCT      = 22;
	localparam int      WATCHDOG_MAX  = 1000;
	localparam int      DRAIN_CYCLES  = 36 + FB + 20;
	localparam longint  INT32_LO      = -64'sd2147483648;
	localparam longint  INT32_HI      = 64'sd2147483647;

	typedef longint unsigned u64_t;

	// one result word as the alu returns it
	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		logic        ovf;
		logic        dz;
	} alu_result_t;

	// wrap to 32 bits, msb of the return is the out-of-range flag
	function automatic logic [32:0] wrap_word(longint v);
		logic ovf;
		ovf = (v < INT32_LO) || (v > INT32_HI);
		return {ovf, v[31:0]};
	endfunction

	function automatic u64_t magnitude(longint v);
		return (v < 0) ? u64_t'(-v) : u64_t'(v);
	endfunction

	// bit-exact prediction of one alu word
	function automatic alu_result_t compute_alu_result(logic [3:0] cmd, logic [31:0] a_raw,
	                                                   logic [31:0] b_raw);
		longint      a, b, v;
		u64_t        m;
		bit          neg;
		alu_result_t r;
		a = longint'($signed(a_raw));
		b = longint'($signed(b_raw));
		r = '0;
		case (cmd)
			CMD_ADD: {r.ovf, r.value} = wrap_word(a + b);
			CMD_SUB: {r.ovf, r.value} = wrap_word(a - b);
			CMD_MUL: begin
				// scale the exact product, round the magnitude half away from zero
				v = a * b;
				neg = v < 0;
				m = (magnitude(v) + (u64_t'(1) << (FB - 1))) >> FB;
				v = neg ? -longint'(m) : longint'(m);
				{r.ovf, r.value} = wrap_word(v);
			end
			CMD_DIV: begin
				if (b == 0) begin
					r.dz = 1'b1;
				end else begin
					v = a * (longint'(1) << FB);
					neg = (v < 0) != (b < 0);
					m = (u64_t'(2) * magnitude(v) + magnitude(b)) / (u64_t'(2) * magnitude(b));
					v = neg ? -longint'(m) : longint'(m);
					{r.ovf, r.value} = wrap_word(v);
				end
			end
			CMD_LT:       r.cmp = a < b;
			CMD_GT:       r.cmp = a > b;
			CMD_LE:       r.cmp = a <= b;
			CMD_GE:       r.cmp = a >= b;
			CMD_EQ:       r.cmp = a == b;
			CMD_NE:       r.cmp = a != b;
			CMD_MIN:      r.value = (a > b) ? b_raw : a_raw;
			CMD_MAX:      r.value = (a > b) ? a_raw : b_raw;
			CMD_INC:      {r.ovf, r.value} = wrap_word(a + longint'($signed(ONE_LSB)));
			CMD_DEC:      {r.ovf, r.value} = wrap_word(a - longint'($signed(ONE_LSB)));
			CMD_TO_INT:   r.value = $signed(a_raw) >>> FB;
			CMD_FROM_INT: {r.ovf, r.value} = wrap_word(a * (longint'(1) << FB));
			default:      r = '0;
		endcase
		return r;
	endfunction

	// queue of predicted words, compared in order against the output stream
	class alu_scoreboard;
		alu_result_t pending_q[$];
		int unsigned mismatches;
		int unsigned compared;
		int unsigned words_in;
		int unsigned ovf_seen;
		int unsigned dz_seen;
		int unsigned true_seen;
		bit          cmd_seen[16];

		function void note_word(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
			pending_q.push_back(compute_alu_result(cmd, a, b));
			cmd_seen[cmd] = 1'b1;
			words_in++;
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
		endfunction

		function void check_word(logic [39:0] word);
			alu_result_t want;
			if (pending_q.size() == 0) begin
				report("unexpected word", 32'h0, word[31:0]);
				return;
			end
			want = pending_q.pop_front();
			compared++;
			if (word[31:0] !== want.value) report("result_value", want.value, word[31:0]);
			if (word[32] !== want.cmp)     report("compare_true", 32'(want.cmp), 32'(word[32]));
			if (word[33] !== want.ovf)     report("overflow", 32'(want.ovf), 32'(word[33]));
			if (word[34] !== want.dz)      report("divide_by_zero", 32'(want.dz), 32'(word[34]));
			if (word[39:35] !== 5'd0)      report("padding", 32'h0, 32'(word[39:35]));
			ovf_seen  += want.ovf;
			dz_seen   += want.dz;
			true_seen += want.cmp;
		endfunction

		function int unsigned pending();
			return pending_q.size();
		endfunction

		function int unsigned commands_hit();
			int unsigned n;
			n = 0;
			foreach (cmd_seen[i]) n += cmd_seen[i];
			return n;
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;   // operand_a[31:0], operand_b[63:32]
	logic [3:0]  s_tuser  = '0;   // command[3:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // result_value[31:0], compare_true[32], overflow[33],
	                              // divide_by_zero[34], zero[39:35]
	bit          calm     = 1'b0;
	int unsigned idle_cycles = 0;

	alu_scoreboard sb = new;

	fixed_point_q24_8_alu i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side back-pressure
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// monitors feed the scoreboard on accepted words
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata[31:0], s_tdata[63:32]);
			if (m_tvalid && m_tready) sb.check_word(m_tdata);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_MAX);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// present one word and hold it until accepted
	task automatic send_word(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {b, a};
		do @(posedge clk); while (!s_tready);
	endtask

	// operand mix: full range, small, corners, whole numbers, mid range
	function automatic logic [31:0] pick_operand();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35) return $urandom;
		if (sel < 55) return 32'(int'($urandom_range(8191)) - 4096);
		if (sel < 70) begin
			case ($urandom_range(7))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				3: return 32'h0000_0001;
				4: return 32'hFFFF_FFFF;
				5: return 32'h0000_0100;
				6: return 32'hFFFF_FF00;
				default: return 32'h0000_0080;
			endcase
		end
		if (sel < 85) return 32'(int'($urandom_range(2000)) - 1000) << FB;
		return 32'(int'($urandom_range(65535)) - 32768);
	endfunction

	initial begin
		logic [31:0] a, b;
		int unsigned sel;

		// reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_word(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
		send_word(CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
		send_word(CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
		send_word(CMD_MUL, 32'h0000_0080, 32'h0000_0001);
		send_word(CMD_MUL, 32'hFFFF_FF80, 32'h0000_0001);
		send_word(CMD_DIV, 32'h1234_5678, 32'h0000_0000);
		send_word(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(CMD_DIV, 32'h0000_0001, 32'h0000_0200);
		send_word(CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
		send_word(CMD_LT, 32'h0000_0100, 32'h0000_0100);
		send_word(CMD_GT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(CMD_LE, 32'h8000_0000, 32'h8000_0000);
		send_word(CMD_GE, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(CMD_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(CMD_NE, 32'h0000_0000, 32'h0000_0000);
		send_word(CMD_MIN, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(CMD_INC, 32'h7FFF_FFFF, 32'h0000_0000);
		send_word(CMD_DEC, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(CMD_TO_INT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(CMD_TO_INT, 32'h8000_0000, 32'h0000_0000);
		send_word(CMD_FROM_INT, 32'h0080_0000, 32'h0000_0000);
		send_word(CMD_FROM_INT, 32'hFF80_0000, 32'h0000_0000);

		// random words, with a stretch of full rate on both sides
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= CALM_FIRST) && (i < CALM_LAST);
			a = pick_operand();
			sel = $urandom_range(99);
			if (sel < 15)      b = a;
			else if (sel < 20) b = '0;
			else               b = pick_operand();
			send_word(4'($urandom_range(15)), a, b);
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then watch a while for stray words
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words sent across %0d of 16 commands, %0d results compared",
		         sb.words_in, sb.commands_hit(), sb.compared);
		$display("flag hits: %0d overflow, %0d divide by zero, %0d compare true",
		         sb.ovf_seen, sb.dz_seen, sb.true_seen);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d field mismatches", sb.mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fxalu_pkg.sv
hw/rtl/fixed_point_q24_8_alu.sv
tb/tb.sv
